>>> design/process_image_access_engine_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the process image access engine
// Shared wrappers for concurrent checks on clk with async reset arst_n.
// ---------------------------------------------------------------------------
`ifndef PROCESS_IMAGE_ACCESS_ENGINE_MACROS_SVH
`define PROCESS_IMAGE_ACCESS_ENGINE_MACROS_SVH

// same-cycle implication
`define PIAE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("piae check failed");

// next-cycle implication
`define PIAE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("piae check failed");

`endif

>>> design/piae_pkg.sv
// ---------------------------------------------------------------------------
// piae_pkg
// Types, codes and constants of the process image access engine.
// ---------------------------------------------------------------------------
`default_nettype none

package piae_pkg;

	localparam int unsigned PIAE_IMAGE_BYTES = 1024;
	localparam int unsigned CFG_W            = 11;
	localparam logic [10:0] IMG_SIZE_RST     = 11'd1024;

	localparam int unsigned S_TDATA_W = 104;
	localparam int unsigned S_TUSER_W = 3;
	localparam int unsigned M_TDATA_W = 40;

	// item kinds
	localparam logic [2:0] KIND_RD_FIELD  = 3'd0;
	localparam logic [2:0] KIND_WR_FIELD  = 3'd1;
	localparam logic [2:0] KIND_MRD       = 3'd2;
	localparam logic [2:0] KIND_MWR       = 3'd3;
	localparam logic [2:0] KIND_FRAME_IN  = 3'd4;
	localparam logic [2:0] KIND_CYCLE     = 3'd5;
	localparam logic [2:0] KIND_CMASK     = 3'd6;
	localparam logic [2:0] KIND_FRAME_OUT = 3'd7;

	// datapath operations per byte
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_RD_SNAP  = 4'd1;
	localparam logic [3:0] OP_RD_LIVE  = 4'd2;
	localparam logic [3:0] OP_WR_BYTES = 4'd3;
	localparam logic [3:0] OP_WR_BIT   = 4'd4;
	localparam logic [3:0] OP_MWR      = 4'd5;
	localparam logic [3:0] OP_FRAME_IN = 4'd6;
	localparam logic [3:0] OP_CMASK    = 4'd7;
	localparam logic [3:0] OP_CYCLE    = 4'd8;

	// result shaping
	localparam logic [1:0] RM_ZERO = 2'd0;
	localparam logic [1:0] RM_ACC  = 2'd1;
	localparam logic [1:0] RM_BIT  = 2'd2;
	localparam logic [1:0] RM_MASK = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_LEN   = 2'd1;
	localparam logic [1:0] ST_BAD_WIDTH = 2'd2;

	typedef struct packed {
		logic accept;
		logic reduce;
		logic clr_wr;
		logic rd;
		logic wr;
		logic fin;
	} piae_cmd_t;

	typedef struct packed {
		logic addr_ge;
		logic out_busy;
	} piae_stat_t;

endpackage

`default_nettype wire

>>> design/piae_ctrl.sv
// ---------------------------------------------------------------------------
// piae_ctrl
// Sequencer: clearing pass, address reduction, byte read/write loop, result.
// ---------------------------------------------------------------------------
`default_nettype none

module piae_ctrl
	import piae_pkg::*;
#(
	parameter int unsigned IMAGE_BYTES = PIAE_IMAGE_BYTES,
	parameter int unsigned CW          = $clog2(IMAGE_BYTES + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output piae_cmd_t          cmd,
	input  wire piae_stat_t    stat,
	input  wire logic [CW-1:0] cnt,
	output logic [CW-1:0]      k
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_REDUCE = 3'd2;
	localparam logic [2:0] S_RD     = 3'd3;
	localparam logic [2:0] S_WR     = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] k_q, k_d;

	assign k = k_q;
	assign s_tready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (k_q == CW'(IMAGE_BYTES - 1)) begin
					state_d = S_IDLE;
					k_d     = '0;
				end else begin
					k_d = k_q + CW'(1);
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					k_d        = '0;
					state_d    = S_REDUCE;
				end
			end
			S_REDUCE: begin
				if (stat.addr_ge) begin
					cmd.reduce = 1'b1;
				end else if (cnt == '0) begin
					state_d = S_FIN;
				end else begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				cmd.wr = 1'b1;
				if ((k_q + CW'(1)) == cnt) begin
					state_d = S_FIN;
				end else begin
					k_d     = k_q + CW'(1);
					state_d = S_RD;
				end
			end
			S_FIN: begin
				if (!stat.out_busy) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

endmodule

`default_nettype wire

>>> design/piae_dpath.sv
// ---------------------------------------------------------------------------
// piae_dpath
// Item decode, five byte-wide image memories, byte merge logic, result reg.
// ---------------------------------------------------------------------------
`default_nettype none

module piae_dpath
	import piae_pkg::*;
#(
	parameter int unsigned IMAGE_BYTES = PIAE_IMAGE_BYTES,
	parameter int unsigned CW          = $clog2(IMAGE_BYTES + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire piae_cmd_t            cmd,
	output piae_stat_t                stat,
	output logic [CW-1:0]             cnt,
	input  wire logic [CW-1:0]        k,
	input  wire logic [CFG_W-1:0]     image_size,
	// item fields
	input  wire logic [2:0]           kind,
	input  wire logic [9:0]           offset,
	input  wire logic [9:0]           extra_offset,
	input  wire logic [2:0]           byte_length,
	input  wire logic [5:0]           field_width,
	input  wire logic [2:0]           bit_index,
	input  wire logic signed [5:0]    bit_select,
	input  wire logic [31:0]          write_value,
	input  wire logic [31:0]          mask,
	// result channel
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata
);

	localparam int unsigned AW = $clog2(IMAGE_BYTES);
	localparam int unsigned RW = (AW + 1 > 11) ? AW + 1 : 11;

	// memories
	logic [7:0] live_mem [IMAGE_BYTES];
	logic [7:0] snap_mem [IMAGE_BYTES];
	logic [7:0] wbuf_mem [IMAGE_BYTES];
	logic [7:0] wmsk_mem [IMAGE_BYTES];
	logic [7:0] cmsk_mem [IMAGE_BYTES];

	logic [7:0] live_rd_q, snap_rd_q, wbuf_rd_q, wmsk_rd_q, cmsk_rd_q;

	// captured item
	logic [1:0]    st_q, rm_q, off_q;
	logic [3:0]    op_q;
	logic [2:0]    cnt_q;
	logic [4:0]    bit_q;
	logic [31:0]   wv_q, msk_q, acc_q;
	logic [RW-1:0] addr_q;
	logic [CW-1:0] ncyc_q;
	logic          chg_q;

	// decode
	logic [1:0]    d_st, d_rm, d_off;
	logic [3:0]    d_op;
	logic [2:0]    d_cnt, nb;
	logic [4:0]    d_bit, bsel5;
	logic [5:0]    weff;
	logic          wok, whole, inrange, bad_len;
	logic [CW-1:0] ncyc;

	always_comb begin
		weff    = (byte_length != 3'd0) ? {byte_length, 3'b000} : field_width;
		wok     = (weff == 6'd1) || (weff == 6'd8) || (weff == 6'd16) || (weff == 6'd32);
		nb      = weff[5:3];
		whole   = bit_select[5];
		bsel5   = bit_select[4:0];
		inrange = ({1'b0, bsel5} < weff);
		bad_len = (kind <= KIND_MWR) && ((byte_length == 3'd3) || (byte_length > 3'd4));
		d_st    = ST_OK;
		d_op    = OP_NONE;
		d_rm    = RM_ZERO;
		d_cnt   = 3'd0;
		d_off   = 2'd0;
		d_bit   = 5'd0;
		if (bad_len) begin
			d_st = ST_BAD_LEN;
		end else begin
			case (kind)
				KIND_RD_FIELD: begin
					if (!wok) begin
						d_st = ST_BAD_WIDTH;
					end else if (weff == 6'd1) begin
						d_op  = OP_RD_SNAP;
						d_cnt = 3'd1;
						d_rm  = RM_BIT;
						d_bit = {2'b00, bit_index};
					end else if (whole) begin
						d_op  = OP_RD_SNAP;
						d_cnt = nb;
						d_rm  = RM_ACC;
					end else if (inrange) begin
						d_op  = OP_RD_SNAP;
						d_cnt = nb;
						d_rm  = RM_BIT;
						d_bit = bsel5;
					end
				end
				KIND_WR_FIELD: begin
					if (!wok) begin
						d_st = ST_BAD_WIDTH;
					end else if (weff == 6'd1) begin
						d_op  = OP_WR_BIT;
						d_cnt = 3'd1;
						d_bit = {2'b00, bit_index};
					end else if (whole) begin
						d_op  = OP_WR_BYTES;
						d_cnt = nb;
					end else if (inrange) begin
						d_op  = OP_WR_BIT;
						d_cnt = 3'd1;
						d_off = bsel5[4:3];
						d_bit = {2'b00, bsel5[2:0]};
					end
				end
				KIND_MRD: begin
					d_op  = OP_RD_SNAP;
					d_cnt = 3'd4;
					d_rm  = RM_MASK;
				end
				KIND_MWR: begin
					d_op  = OP_MWR;
					d_cnt = 3'd4;
				end
				KIND_FRAME_IN: begin
					d_op  = OP_FRAME_IN;
					d_cnt = 3'd1;
				end
				KIND_CYCLE: begin
					d_op = OP_CYCLE;
				end
				KIND_CMASK: begin
					d_op  = OP_CMASK;
					d_cnt = 3'd1;
				end
				default: begin
					d_op  = OP_RD_LIVE;
					d_cnt = 3'd1;
					d_rm  = RM_ACC;
				end
			endcase
		end
		// bytes walked by a cycle item
		if (32'(image_size) > 32'(IMAGE_BYTES)) begin
			ncyc = CW'(IMAGE_BYTES);
		end else begin
			ncyc = CW'(image_size);
		end
	end

	// item capture and address reduction
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			st_q   <= d_st;
			op_q   <= d_op;
			rm_q   <= d_rm;
			cnt_q  <= d_cnt;
			off_q  <= d_off;
			bit_q  <= d_bit;
			wv_q   <= write_value;
			msk_q  <= mask;
			ncyc_q <= ncyc;
			addr_q <= RW'(offset) + RW'(extra_offset);
		end else if (cmd.reduce) begin
			addr_q <= addr_q - RW'(IMAGE_BYTES);
		end
	end

	assign stat.addr_ge  = (addr_q >= RW'(IMAGE_BYTES));
	assign stat.out_busy = m_tvalid && !m_tready;
	assign cnt = (op_q == OP_CYCLE) ? ncyc_q : CW'(cnt_q);

	// byte address with wrap
	logic [AW:0]   sum;
	logic [AW-1:0] ma;
	always_comb begin
		sum = {1'b0, addr_q[AW-1:0]} + (AW+1)'(off_q) + (AW+1)'(k[1:0]);
		if (cmd.clr_wr || (op_q == OP_CYCLE)) begin
			ma = k[AW-1:0];
		end else if (sum >= (AW+1)'(IMAGE_BYTES)) begin
			ma = AW'(sum - (AW+1)'(IMAGE_BYTES));
		end else begin
			ma = AW'(sum);
		end
	end

	// per-byte write data
	logic [7:0] wvb, mb, bm;
	logic       we_live, we_snap, we_wbuf, we_wmsk, we_cmsk;
	logic [7:0] wd_live, wd_snap, wd_wbuf, wd_wmsk, wd_cmsk;
	logic [CW-1:0] lim;

	always_comb begin
		wvb     = wv_q[{k[1:0], 3'b000} +: 8];
		mb      = msk_q[{k[1:0], 3'b000} +: 8];
		bm      = 8'd1 << bit_q[2:0];
		lim     = {ncyc_q[CW-1:2], 2'b00};
		we_live = 1'b0;
		we_snap = 1'b0;
		we_wbuf = 1'b0;
		we_wmsk = 1'b0;
		we_cmsk = 1'b0;
		wd_live = 8'd0;
		wd_snap = 8'd0;
		wd_wbuf = 8'd0;
		wd_wmsk = 8'd0;
		wd_cmsk = 8'd0;
		if (cmd.clr_wr) begin
			we_live = 1'b1;
			we_snap = 1'b1;
			we_wbuf = 1'b1;
			we_wmsk = 1'b1;
			we_cmsk = 1'b1;
		end else if (cmd.wr) begin
			case (op_q)
				OP_WR_BYTES: begin
					we_wbuf = 1'b1;
					wd_wbuf = wvb;
					we_wmsk = 1'b1;
					wd_wmsk = 8'hff;
				end
				OP_WR_BIT: begin
					we_wbuf = 1'b1;
					wd_wbuf = wv_q[0] ? (wbuf_rd_q | bm) : (wbuf_rd_q & ~bm);
					we_wmsk = 1'b1;
					wd_wmsk = wmsk_rd_q | bm;
				end
				OP_MWR: begin
					we_wbuf = 1'b1;
					wd_wbuf = (wbuf_rd_q & ~mb) | wvb;
					we_wmsk = 1'b1;
					wd_wmsk = wmsk_rd_q | mb;
				end
				OP_FRAME_IN: begin
					we_live = 1'b1;
					wd_live = wv_q[7:0];
				end
				OP_CMASK: begin
					we_cmsk = 1'b1;
					wd_cmsk = wv_q[7:0];
				end
				OP_CYCLE: begin
					we_snap = 1'b1;
					wd_snap = live_rd_q;
					we_live = 1'b1;
					wd_live = (live_rd_q & ~wmsk_rd_q) | wbuf_rd_q;
					we_wmsk = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// memory ports: one address, registered read
	always_ff @(posedge clk) begin
		if (we_live) live_mem[ma] <= wd_live;
		if (we_snap) snap_mem[ma] <= wd_snap;
		if (we_wbuf) wbuf_mem[ma] <= wd_wbuf;
		if (we_wmsk) wmsk_mem[ma] <= wd_wmsk;
		if (we_cmsk) cmsk_mem[ma] <= wd_cmsk;
		if (cmd.rd) begin
			live_rd_q <= live_mem[ma];
			snap_rd_q <= snap_mem[ma];
			wbuf_rd_q <= wbuf_mem[ma];
			wmsk_rd_q <= wmsk_mem[ma];
			cmsk_rd_q <= cmsk_mem[ma];
		end
	end

	// read accumulation and change detect
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			acc_q <= '0;
			chg_q <= 1'b0;
		end else if (cmd.wr) begin
			if (op_q == OP_RD_SNAP) begin
				acc_q <= acc_q | (32'(snap_rd_q) << {k[1:0], 3'b000});
			end else if (op_q == OP_RD_LIVE) begin
				acc_q <= 32'(live_rd_q);
			end
			if ((op_q == OP_CYCLE) && (k < lim) &&
			    (((snap_rd_q ^ live_rd_q) & cmsk_rd_q) != 8'd0)) begin
				chg_q <= 1'b1;
			end
		end
	end

	// result shaping
	logic [31:0] rv;
	always_comb begin
		case (rm_q)
			RM_ACC:  rv = acc_q;
			RM_BIT:  rv = {31'd0, acc_q[bit_q]};
			RM_MASK: rv = acc_q & msk_q;
			default: rv = 32'd0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.fin) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			m_tdata <= {5'd0, chg_q, st_q, rv};
		end
	end

endmodule

`default_nettype wire

>>> design/process_image_access_engine.sv
// ---------------------------------------------------------------------------
// process_image_access_engine
// Fieldbus process image engine: field access, frame bytes, cycle merge.
// ---------------------------------------------------------------------------
//  channel  | dir | contents
//  s_*      | in  | item: tuser kind, tdata fields
//  m_*      | out | result: read_value, status, changed
//  p*       | cfg | APB, image_size at byte address 0
//
//  Per item: address reduction by IMAGE_BYTES steps until in range, then
//  a read and a write of each byte in the single-address byte memories,
//  then the result.  A cycle item walks min(image_size, IMAGE_BYTES)
//  bytes.  After reset a clearing pass over all IMAGE_BYTES addresses
//  zeroes all memories; s_tready stays low meanwhile.  A held result
//  does not block the next item until its result is due.
// ---------------------------------------------------------------------------
`default_nettype none

module process_image_access_engine
	import piae_pkg::*;
#(
	parameter int unsigned IMAGE_BYTES = PIAE_IMAGE_BYTES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// tuser: kind[2:0]
	// tdata: offset[9:0], extra_offset[19:10], byte_length[22:20],
	//        field_width[28:23], bit_index[31:29], bit_select[37:32],
	//        write_value[69:38], mask[101:70], zero fill
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic [S_TUSER_W-1:0] s_tuser,
	// tdata: read_value[31:0], status[33:32], changed[34], zero fill
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	localparam int unsigned CW = $clog2(IMAGE_BYTES + 1);

	logic [CFG_W-1:0] image_size_q;
	piae_cmd_t        cmd;
	piae_stat_t       stat;
	logic [CW-1:0]    cnt, k;

	// configuration register
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {21'd0, image_size_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= IMG_SIZE_RST;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			image_size_q <= pwdata[CFG_W-1:0];
		end
	end

	piae_ctrl #(
		.IMAGE_BYTES(IMAGE_BYTES),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.cmd(cmd),
		.stat(stat),
		.cnt(cnt),
		.k(k)
	);

	piae_dpath #(
		.IMAGE_BYTES(IMAGE_BYTES),
		.CW(CW)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.cnt(cnt),
		.k(k),
		.image_size(image_size_q),
		.kind(s_tuser),
		.offset(s_tdata[9:0]),
		.extra_offset(s_tdata[19:10]),
		.byte_length(s_tdata[22:20]),
		.field_width(s_tdata[28:23]),
		.bit_index(s_tdata[31:29]),
		.bit_select(s_tdata[37:32]),
		.write_value(s_tdata[69:38]),
		.mask(s_tdata[101:70]),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule

`default_nettype wire

>>> design/piae_checker.sv
// ---------------------------------------------------------------------------
// piae_checker
// Port-level checks of the process image access engine, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "process_image_access_engine_macros.svh"

module piae_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);

	// a stalled result beat holds
	`PIAE_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// status code stays in its range
	`PIAE_ASSERT_IMP(a_status, m_tvalid, m_tdata[33:32] != 2'd3)

	// change flag only on a clean cycle item, which reads nothing
	`PIAE_ASSERT_IMP(a_chg, m_tvalid && m_tdata[34],
		(m_tdata[33:32] == 2'd0) && (m_tdata[31:0] == 32'd0))

	// an accepted item keeps the block busy the next cycle
	`PIAE_ASSERT_NXT(a_busy, s_tvalid && s_tready, !s_tready)

endmodule

bind process_image_access_engine piae_checker u_piae_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

`default_nettype wire

>>> sim/process_image_access_engine_test.sv
// ---------------------------------------------------------------------------
// process_image_access_engine_test
// Self-checking bench: a directed table and random streams of field accesses,
// frame bytes and cycle items, each result compared with a built-in model of
// the image memories. Several image sizes are programmed over APB.
// ---------------------------------------------------------------------------
`default_nettype none

module process_image_access_engine_test;
	import piae_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NB = PIAE_IMAGE_BYTES;

	typedef struct packed {
		logic [2:0]  kind;
		logic [9:0]  offset;
		logic [9:0]  extra;
		logic [2:0]  blen;
		logic [5:0]  width;
		logic [2:0]  bidx;
		logic [5:0]  bsel;
		logic [31:0] wval;
		logic [31:0] msk;
	} item_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [1:0]  status;
		logic        changed;
	} res_t;

	// one row of the directed table; chk marks a typed-in expectation
	typedef struct packed {
		item_t it;
		logic  chk;
		res_t  res;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [2:0]           paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	process_image_access_engine dut (.*);

	// model state
	logic [7:0]  live_img [NB];
	logic [7:0]  snap_img [NB];
	logic [7:0]  wr_buf [NB];
	logic [7:0]  wr_msk [NB];
	logic [7:0]  chg_msk [NB];
	logic [10:0] img_size;

	res_t pending_res [$];
	int   n_err;
	int   n_beats;
	int   n_cycles;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] load_word(ref logic [7:0] mem [NB], input int a, int n);
		logic [31:0] v;
		v = '0;
		for (int k = 0; k < n; k++)
			v |= 32'(mem[(a + k) % NB]) << (8 * k);
		return v;
	endfunction

	function automatic void store_word(ref logic [7:0] mem [NB], input int a, int n,
			logic [31:0] v);
		for (int k = 0; k < n; k++)
			mem[(a + k) % NB] = v[8*k +: 8];
	endfunction

	// advance the image model by one item and return its result
	function automatic res_t image_step(item_t it);
		res_t r;
		int a, w, nb, n;
		logic [31:0] d, m, bitv;
		logic whole;
		r = '0;
		a = (int'(it.offset) + int'(it.extra)) % NB;
		w = it.width;
		whole = it.bsel[5];
		if (it.kind <= KIND_MWR) begin
			if (it.blen == 3 || it.blen > 4) r.status = ST_BAD_LEN;
			else if (it.blen != 0) w = 8 * it.blen;
		end
		if (r.status == ST_OK) begin
			case (it.kind)
				KIND_RD_FIELD: begin
					if (w == 1) r.read_value = 32'((snap_img[a] >> it.bidx) & 8'h1);
					else if (w == 8 || w == 16 || w == 32) begin
						d = load_word(snap_img, a, w / 8);
						if (whole) r.read_value = d;
						else if (it.bsel[4:0] < w) r.read_value = 32'(d[it.bsel[4:0]]);
					end else r.status = ST_BAD_WIDTH;
				end
				KIND_WR_FIELD: begin
					if (w == 1) begin
						wr_buf[a][it.bidx] = it.wval[0];
						wr_msk[a][it.bidx] = 1'b1;
					end else if (w == 8 || w == 16 || w == 32) begin
						nb = w / 8;
						if (whole) begin
							store_word(wr_buf, a, nb, it.wval);
							store_word(wr_msk, a, nb, 32'hffffffff);
						end else if (it.bsel[4:0] < w) begin
							bitv = 32'h1 << it.bsel[4:0];
							d = load_word(wr_buf, a, nb);
							m = load_word(wr_msk, a, nb);
							d = it.wval[0] ? (d | bitv) : (d & ~bitv);
							store_word(wr_buf, a, nb, d);
							store_word(wr_msk, a, nb, m | bitv);
						end
					end else r.status = ST_BAD_WIDTH;
				end
				KIND_MRD: r.read_value = load_word(snap_img, a, 4) & it.msk;
				KIND_MWR: begin
					d = load_word(wr_buf, a, 4);
					m = load_word(wr_msk, a, 4);
					store_word(wr_buf, a, 4, (d & ~it.msk) | it.wval);
					store_word(wr_msk, a, 4, m | it.msk);
				end
				KIND_FRAME_IN: live_img[a] = it.wval[7:0];
				KIND_CYCLE: begin
					n = (img_size > NB) ? NB : img_size;
					for (int i = 0; i < (n / 4) * 4; i++)
						if (((snap_img[i] ^ live_img[i]) & chg_msk[i]) != 0) r.changed = 1'b1;
					for (int i = 0; i < n; i++) begin
						snap_img[i] = live_img[i];
						live_img[i] = (live_img[i] & ~wr_msk[i]) | wr_buf[i];
						wr_msk[i] = '0;
					end
				end
				KIND_CMASK: chg_msk[a] = it.wval[7:0];
				default: r.read_value = 32'(live_img[a]);
			endcase
		end
		if (r.status != ST_OK) r.read_value = '0;
		return r;
	endfunction

	function automatic item_t mk(logic [2:0] k, int off, int ext, int bl, int w, int bi,
			int bs, logic [31:0] wv, logic [31:0] ms);
		item_t it;
		it.kind = k; it.offset = 10'(off); it.extra = 10'(ext); it.blen = 3'(bl);
		it.width = 6'(w); it.bidx = 3'(bi); it.bsel = 6'(bs); it.wval = wv; it.msk = ms;
		return it;
	endfunction

	function automatic int short_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
	endfunction

	// send one beat, queue its expected result
	task automatic send_item(item_t it, logic chk, res_t typed);
		res_t r;
		int   g;
		s_tvalid <= 1'b1;
		s_tuser <= it.kind;
		s_tdata <= {2'b0, it.msk, it.wval, it.bsel, it.bidx, it.width, it.blen,
			it.extra, it.offset};
		do @(posedge clk); while (!s_tready);
		r = image_step(it);
		if (chk && r != typed) begin
			$error("table row disagrees with model: exp %h got %h", typed, r);
			n_err++;
		end
		pending_res.push_back(chk ? typed : r);
		if (it.kind == KIND_CYCLE) n_cycles++;
		n_beats++;
		g = short_gap();
		if (g != 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (pending_res.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (2100) @(posedge clk);
	endtask

	task automatic write_size(logic [10:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		img_size = v;
		@(posedge clk);
	endtask

	function automatic item_t rand_item();
		item_t it;
		int sel;
		logic [2:0] ks [8] = '{KIND_RD_FIELD, KIND_WR_FIELD, KIND_MRD, KIND_MWR,
			KIND_FRAME_IN, KIND_CYCLE, KIND_CMASK, KIND_FRAME_OUT};
		int ws [5] = '{1, 8, 16, 32, 0};
		sel = $urandom_range(0, 99);
		it.kind = (sel < 4) ? KIND_CYCLE : ks[$urandom_range(0, 7)];
		if (it.kind == KIND_CYCLE && sel >= 4) it.kind = KIND_FRAME_IN;
		it.offset = 10'($urandom());
		it.extra = ($urandom_range(0, 2) == 0) ? 10'($urandom()) : 10'd0;
		// small offsets for about half the items so cycles over small sizes see the activity
		if ($urandom_range(0, 1)) begin
			it.offset = 10'($urandom_range(0, 63));
			it.extra = 10'd0;
		end
		sel = $urandom_range(0, 9);
		it.blen = (sel < 6) ? 3'd0 : (sel < 9) ? 3'(1 << $urandom_range(0, 2)) : 3'($urandom());
		it.width = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
			: 6'(ws[$urandom_range(0, 3)]);
		it.bidx = 3'($urandom());
		it.bsel = ($urandom_range(0, 1)) ? 6'h3f : 6'($urandom());
		it.wval = $urandom();
		it.msk = $urandom();
		return it;
	endfunction

	// result side: random stalls and in-order compare
	initial begin
		res_t got, want;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.read_value = m_tdata[31:0];
				got.status     = m_tdata[33:32];
				got.changed    = m_tdata[34];
				if (pending_res.size() == 0) begin
					$error("result beat with nothing expected: %h", got);
					n_err++;
				end else begin
					want = pending_res.pop_front();
					if (got.read_value !== want.read_value) begin
						$error("read_value exp %h got %h", want.read_value, got.read_value);
						n_err++;
					end
					if (got.status !== want.status) begin
						$error("status exp %0d got %0d", want.status, got.status);
						n_err++;
					end
					if (got.changed !== want.changed) begin
						$error("changed exp %0d got %0d", want.changed, got.changed);
						n_err++;
					end
				end
			end
			m_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		#300ms;
		$display("** process_image_access_engine: FAILED **");
		$finish;
	end

	// stimulus
	initial begin
		row_t tbl [$];
		logic [10:0] sizes [4] = '{11'd4, 11'd1024, 11'd64, 11'd2047};
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		n_err = 0; n_beats = 0; n_cycles = 0;
		img_size = IMG_SIZE_RST;
		for (int i = 0; i < NB; i++) begin
			live_img[i] = 0; snap_img[i] = 0; wr_buf[i] = 0; wr_msk[i] = 0; chg_msk[i] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: typed expectations after reset and for error codes
		tbl.push_back('{mk(KIND_MRD, 0, 0, 0, 0, 0, 0, 0, 32'hffffffff), 1, '0});
		tbl.push_back('{mk(KIND_RD_FIELD, 1023, 1023, 3, 8, 0, 63, 0, 0), 1,
			'{0, ST_BAD_LEN, 0}});
		tbl.push_back('{mk(KIND_WR_FIELD, 5, 0, 7, 8, 0, 63, 1, 0), 1, '{0, ST_BAD_LEN, 0}});
		tbl.push_back('{mk(KIND_MWR, 5, 0, 5, 0, 0, 63, 1, 1), 1, '{0, ST_BAD_LEN, 0}});
		tbl.push_back('{mk(KIND_RD_FIELD, 0, 0, 0, 5, 0, 63, 0, 0), 1,
			'{0, ST_BAD_WIDTH, 0}});
		tbl.push_back('{mk(KIND_WR_FIELD, 0, 0, 0, 63, 0, 63, 0, 0), 1,
			'{0, ST_BAD_WIDTH, 0}});
		tbl.push_back('{mk(KIND_FRAME_IN, 1023, 0, 0, 0, 0, 0, 32'hffffffa5, 0), 1, '0});
		tbl.push_back('{mk(KIND_FRAME_IN, 0, 0, 0, 0, 0, 0, 32'h3c, 0), 1, '0});
		tbl.push_back('{mk(KIND_FRAME_OUT, 1000, 23, 0, 0, 0, 0, 0, 0), 1,
			'{32'ha5, ST_OK, 0}});
		tbl.push_back('{mk(KIND_CMASK, 0, 0, 0, 0, 0, 0, 32'hff, 0), 1, '0});
		tbl.push_back('{mk(KIND_CYCLE, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{0, ST_OK, 1}});
		// wrapped 16-bit read across the top of the image
		tbl.push_back('{mk(KIND_RD_FIELD, 1023, 0, 0, 16, 0, 63, 0, 0), 1,
			'{32'h3ca5, ST_OK, 0}});
		tbl.push_back('{mk(KIND_RD_FIELD, 1023, 0, 2, 0, 0, 8, 0, 0), 0, '0});
		tbl.push_back('{mk(KIND_RD_FIELD, 0, 0, 0, 8, 0, 20, 0, 0), 1, '0});
		tbl.push_back('{mk(KIND_RD_FIELD, 0, 0, 0, 1, 7, 0, 0, 0), 0, '0});
		tbl.push_back('{mk(KIND_WR_FIELD, 8, 0, 0, 32, 0, 63, 32'hffffffff, 0), 0, '0});
		tbl.push_back('{mk(KIND_WR_FIELD, 12, 0, 4, 0, 0, 31, 1, 0), 0, '0});
		tbl.push_back('{mk(KIND_WR_FIELD, 16, 0, 0, 1, 3, 0, 1, 0), 0, '0});
		tbl.push_back('{mk(KIND_WR_FIELD, 20, 0, 1, 0, 0, 12, 1, 0), 0, '0});
		tbl.push_back('{mk(KIND_MWR, 1022, 0, 0, 0, 0, 0, 32'hdeadbeef, 32'h0000ffff), 0, '0});
		tbl.push_back('{mk(KIND_CYCLE, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
		tbl.push_back('{mk(KIND_CYCLE, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
		tbl.push_back('{mk(KIND_MRD, 8, 0, 0, 0, 0, 0, 0, 32'hffffffff), 0, '0});
		tbl.push_back('{mk(KIND_MRD, 1022, 0, 0, 0, 0, 0, 0, 32'h00ff00ff), 0, '0});
		tbl.push_back('{mk(KIND_RD_FIELD, 12, 0, 0, 32, 0, 31, 0, 0), 0, '0});
		foreach (tbl[i]) send_item(tbl[i].it, tbl[i].chk, tbl[i].res);
		// hold off until the directed results have all come back
		drain();

		// random phases over several image sizes
		foreach (sizes[p]) begin
			write_size(sizes[p]);
			for (int i = 0; i < 335; i++) send_item(rand_item(), 1'b0, '0);
			drain();
		end

		$display("covered %0d item beats, %0d cycle items, image sizes 4 to 2047",
			n_beats, n_cycles);
		if (n_err == 0 && pending_res.size() == 0)
			$display("** process_image_access_engine: PASSED **");
		else
			$display("** process_image_access_engine: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+design
design/piae_pkg.sv
design/piae_ctrl.sv
design/piae_dpath.sv
design/process_image_access_engine.sv
design/piae_checker.sv
sim/process_image_access_engine_test.sv
